>>> rtl/svu_pkg.sv
// ----------------------------------------------------------------------------
// svu_pkg
// Shared types and constants for the simplex vertex unrank step block.
// ----------------------------------------------------------------------------
`default_nettype none

package svu_pkg;

    // Field widths fixed by the interface
    localparam int VTX_W   = 9;
    localparam int DIM_W   = 4;
    localparam int RANK_W  = 63;
    localparam int COEFF_W = 64;

    // Largest values the register fields can carry
    localparam int VTX_FIELD_MAX = (1 << VTX_W) - 1;
    localparam int DIM_FIELD_MAX = (1 << DIM_W) - 1;

    // Register indexes on the configuration port
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_DIM_LIMIT    = 1'b1;

    localparam logic [COEFF_W-1:0] COEFF_ONE  = 64'd1;
    localparam logic [COEFF_W-1:0] COEFF_ZERO = 64'd0;

    // Input item
    typedef struct packed {
        logic [VTX_W-1:0]  start_vertex;
        logic [RANK_W-1:0] rank_value;
        logic [DIM_W-1:0]  subset_size;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             error;
    } t_out_item;

    // Operations of the shared arithmetic unit
    typedef enum logic {
        ALU_ADD_SAT,
        ALU_LESS
    } t_alu_op;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_CHECK,
        ST_CMP0,
        ST_SRCH,
        ST_SCMP,
        ST_FCMP,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/svu_alu.sv
// ----------------------------------------------------------------------------
// svu_alu
// Shared 64-bit unit: saturating add for the table build, less-than compare
// for the search. One carry chain serves both.
// ----------------------------------------------------------------------------
`default_nettype none

module svu_alu (
    input  var svu_pkg::t_alu_op                 i_op,
    input  var logic [svu_pkg::COEFF_W-1:0]      i_a,
    input  var logic [svu_pkg::COEFF_W-1:0]      i_b,
    output var logic [svu_pkg::COEFF_W-1:0]      o_sum,
    output var logic                             o_lt
);

    logic [svu_pkg::COEFF_W-1:0] w_b;
    logic                        w_cin;
    logic [svu_pkg::COEFF_W:0]   w_res;

    // Subtract by inverting b and feeding a carry in
    always_comb begin
        w_b   = (i_op == svu_pkg::ALU_LESS) ? ~i_b : i_b;
        w_cin = (i_op == svu_pkg::ALU_LESS);
        w_res = {1'b0, i_a} + {1'b0, w_b} + {{svu_pkg::COEFF_W{1'b0}}, w_cin};
    end

    // Sum saturates at all ones; a borrow (no carry out) means a < b
    assign o_sum = w_res[svu_pkg::COEFF_W] ? {svu_pkg::COEFF_W{1'b1}}
                                           : w_res[svu_pkg::COEFF_W-1:0];
    assign o_lt  = ~w_res[svu_pkg::COEFF_W];

endmodule

`default_nettype wire

>>> rtl/svu_table.sv
// ----------------------------------------------------------------------------
// svu_table
// Binomial coefficient store: one write port, one read port, registered
// read data. Contents are undefined until the build pass writes them.
// ----------------------------------------------------------------------------
`default_nettype none

module svu_table #(
    parameter int DEPTH = 2313,
    parameter int AW    = 12
) (
    input  var logic                          i_clk,
    input  var logic                          i_we,
    input  var logic [AW-1:0]                 i_waddr,
    input  var logic [svu_pkg::COEFF_W-1:0]   i_wdata,
    input  var logic [AW-1:0]                 i_raddr,
    output var logic [svu_pkg::COEFF_W-1:0]   o_rdata
);

    logic [svu_pkg::COEFF_W-1:0] r_mem [DEPTH];
    logic [svu_pkg::COEFF_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered and presented in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/simplex_vertex_unrank_step.sv
// ----------------------------------------------------------------------------
// simplex_vertex_unrank_step
// Largest vertex v <= start with C(v,k) <= rank, by binary search over a
// Pascal-triangle table of binomial coefficients held in a local memory.
// ----------------------------------------------------------------------------
// The block takes one item at a time. The first item after reset or after
// any register write rebuilds the binomial table first, one entry a cycle:
// (vertex_count+1)*(dim_limit+1) entries, 2313 with the reset values. After
// that an item goes through the range check and first table read, a compare
// of the start vertex, binary-search steps (each a table read, then a compare
// in the shared 64-bit unit), the closing check, and last the result. An item
// outside the table goes straight to an error result, and the search and the
// closing check are skipped when the start vertex already qualifies. The single
// table read port and the one shared adder/comparator make each search step a
// read then a compare. Results are held in an output register until taken; a
// new item is accepted once it has gone.
`default_nettype none

module simplex_vertex_unrank_step #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_DIM      = 8
) (
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    // input items
    input  var logic                  i_in_valid,
    output var logic                  o_in_ready,
    input  var svu_pkg::t_in_item     i_in_data,
    // result items
    output var logic                  o_out_valid,
    input  var logic                  i_out_ready,
    output var svu_pkg::t_out_item    o_out_data,
    // configuration port
    input  var logic                  psel,
    input  var logic                  penable,
    input  var logic                  pwrite,
    input  var logic [2:0]            paddr,
    input  var logic [31:0]           pwdata,
    output var logic [31:0]           prdata,
    output var logic                  pready
);

    // Indices are bounded by the register field widths as well
    localparam int NV    = (MAX_VERTICES < svu_pkg::VTX_FIELD_MAX) ?
                           MAX_VERTICES : svu_pkg::VTX_FIELD_MAX;
    localparam int ND    = (MAX_DIM < svu_pkg::DIM_FIELD_MAX) ?
                           MAX_DIM : svu_pkg::DIM_FIELD_MAX;
    localparam int ROW   = ND + 1;
    localparam int DEPTH = (NV + 1) * ROW;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = $clog2(ROW);
    localparam int VC_RST = (256 < NV) ? 256 : NV;
    localparam int DL_RST = (8 < ND) ? 8 : ND;

    localparam int VW = svu_pkg::VTX_W;
    localparam int KW = svu_pkg::DIM_W;
    localparam int CW = svu_pkg::COEFF_W;

    svu_pkg::t_state r_state, n_state;

    logic [VW-1:0]          r_vc, n_vc;
    logic [KW-1:0]          r_dl, n_dl;
    logic                   r_tbl_ok, n_tbl_ok;

    logic [VW-1:0]          r_v, n_v;
    logic [VW-1:0]          r_count, n_count;
    logic [VW-1:0]          r_idx, n_idx;
    logic [svu_pkg::RANK_W-1:0] r_rank, n_rank;
    logic [KW-1:0]          r_k, n_k;

    logic [VW-1:0]          r_bi, n_bi;
    logic [KW-1:0]          r_bj, n_bj;
    logic [AW-1:0]          r_base, n_base;
    logic [CW-1:0]          r_prev, n_prev;
    logic [CW-1:0]          r_row [ROW];

    svu_pkg::t_out_item     r_out, n_out;

    logic                   w_cfg_wr;
    logic [VW-1:0]          w_step;
    logic [VW-1:0]          w_sidx;
    logic [AW-1:0]          w_raddr;
    logic [AW-1:0]          w_waddr;
    logic                   w_we;
    logic [CW-1:0]          w_coeff;
    logic [CW-1:0]          w_rdata;
    logic [CW-1:0]          w_row_j;
    svu_pkg::t_alu_op       w_op;
    logic [CW-1:0]          w_a, w_b, w_sum;
    logic                   w_lt;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign prdata   = (paddr[2] == svu_pkg::REG_DIM_LIMIT) ? {28'd0, r_dl}
                                                           : {23'd0, r_vc};

    // Search probe index and table addresses
    assign w_step  = r_count >> 1;
    assign w_sidx  = (r_state == svu_pkg::ST_SRCH && r_count != '0) ?
                     (r_v - w_step) : r_v;
    assign w_raddr = AW'(w_sidx) * AW'(ROW) + AW'(r_k);
    assign w_waddr = r_base + AW'(r_bj);
    assign w_row_j = r_row[r_bj[JW-1:0]];

    // Shared unit: saturating add while building, rank < coeff otherwise
    always_comb begin
        if (r_state == svu_pkg::ST_BUILD) begin
            w_op = svu_pkg::ALU_ADD_SAT;
            w_a  = r_prev;
            w_b  = w_row_j;
        end else begin
            w_op = svu_pkg::ALU_LESS;
            w_a  = {1'b0, r_rank};
            w_b  = w_rdata;
        end
    end

    svu_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_sum (w_sum),
        .o_lt  (w_lt)
    );

    // Pascal rule for the entry being built
    always_comb begin
        if (KW'(r_bj) > r_bi[KW-1:0] && r_bi < VW'(1 << KW)) begin
            w_coeff = svu_pkg::COEFF_ZERO;
        end else if (r_bj == '0 || VW'(r_bj) == r_bi) begin
            w_coeff = svu_pkg::COEFF_ONE;
        end else begin
            w_coeff = w_sum;
        end
    end
    assign w_we = (r_state == svu_pkg::ST_BUILD);

    svu_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_coeff),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Row buffer holds the previous row, updated in place
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_row[r_bj[JW-1:0]] <= w_coeff;
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_vc     = r_vc;
        n_dl     = r_dl;
        n_tbl_ok = r_tbl_ok;
        n_v      = r_v;
        n_count  = r_count;
        n_idx    = r_idx;
        n_rank   = r_rank;
        n_k      = r_k;
        n_bi     = r_bi;
        n_bj     = r_bj;
        n_base   = r_base;
        n_prev   = r_prev;
        n_out    = r_out;

        // register writes, saturated to the table bounds
        if (w_cfg_wr) begin
            if (paddr[2] == svu_pkg::REG_VERTEX_COUNT) begin
                n_vc = (int'(pwdata[VW-1:0]) > NV) ? VW'(NV) : pwdata[VW-1:0];
            end else begin
                n_dl = (int'(pwdata[KW-1:0]) > ND) ? KW'(ND) : pwdata[KW-1:0];
            end
            n_tbl_ok = 1'b0;
        end

        case (r_state)
            svu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_v    = i_in_data.start_vertex;
                    n_rank = i_in_data.rank_value;
                    n_k    = i_in_data.subset_size;
                    n_bi   = '0;
                    n_bj   = '0;
                    n_base = '0;
                    n_state = r_tbl_ok ? svu_pkg::ST_CHECK : svu_pkg::ST_BUILD;
                end
            end
            svu_pkg::ST_BUILD: begin
                // one entry a cycle; carry old row[j] on as row[j-1]
                n_prev = w_row_j;
                if (r_bj == r_dl) begin
                    n_bj = '0;
                    if (r_bi == r_vc) begin
                        n_tbl_ok = 1'b1;
                        n_state  = svu_pkg::ST_CHECK;
                    end else begin
                        n_bi   = r_bi + VW'(1);
                        n_base = r_base + AW'(ROW);
                    end
                end else begin
                    n_bj = r_bj + KW'(1);
                end
            end
            svu_pkg::ST_CHECK: begin
                // arguments outside the table give an error item
                if (r_v > r_vc || r_k > r_dl) begin
                    n_out.vertex = '0;
                    n_out.error  = 1'b1;
                    n_state      = svu_pkg::ST_OUT;
                end else begin
                    n_state = svu_pkg::ST_CMP0;
                end
            end
            svu_pkg::ST_CMP0: begin
                // start already qualifies: return it unchanged
                if (w_lt) begin
                    n_count = r_v;
                    n_state = svu_pkg::ST_SRCH;
                end else begin
                    n_out.vertex = r_v;
                    n_out.error  = 1'b0;
                    n_state      = svu_pkg::ST_OUT;
                end
            end
            svu_pkg::ST_SRCH: begin
                // read issued at the probe; count zero means closing check
                n_idx   = w_sidx;
                n_state = (r_count == '0) ? svu_pkg::ST_FCMP : svu_pkg::ST_SCMP;
            end
            svu_pkg::ST_SCMP: begin
                if (w_lt) begin
                    n_v     = (r_idx != '0) ? (r_idx - VW'(1)) : '0;
                    n_count = r_count - w_step - VW'(1);
                end else begin
                    n_count = w_step;
                end
                n_state = svu_pkg::ST_SRCH;
            end
            svu_pkg::ST_FCMP: begin
                // no qualifying vertex ends at zero with error
                n_out.vertex = w_lt ? '0 : r_v;
                n_out.error  = w_lt;
                n_state      = svu_pkg::ST_OUT;
            end
            svu_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = svu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = svu_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= svu_pkg::ST_IDLE;
            r_vc     <= VW'(VC_RST);
            r_dl     <= KW'(DL_RST);
            r_tbl_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vc     <= n_vc;
            r_dl     <= n_dl;
            r_tbl_ok <= n_tbl_ok;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_count <= n_count;
        r_idx   <= n_idx;
        r_rank  <= n_rank;
        r_k     <= n_k;
        r_bi    <= n_bi;
        r_bj    <= n_bj;
        r_base  <= n_base;
        r_prev  <= n_prev;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == svu_pkg::ST_IDLE);
    assign o_out_valid = (r_state == svu_pkg::ST_OUT);
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> test/simplex_vertex_unrank_step_tb.sv
// ----------------------------------------------------------------------------
// simplex_vertex_unrank_step_tb
// Self-checking bench for the next-vertex search. Items go in through a
// valid/ready channel and each result is compared with a local binomial
// search over Pascal's triangle, under several register settings written
// over the APB port. Directed corner items come first, then random phases.
// ----------------------------------------------------------------------------
`default_nettype none

module simplex_vertex_unrank_step_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_VERTEX = 256;
    localparam int TOP_DIM    = 8;

    // Clock, reset and block ports
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    svu_pkg::t_in_item  i_in_data  = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    svu_pkg::t_out_item o_out_data;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    // Pascal's triangle, saturating, for the largest table the block can hold
    logic [svu_pkg::COEFF_W-1:0] pascal [0:TOP_VERTEX][0:TOP_DIM];

    // Register values as the block should hold them
    int unsigned cfg_vertex_count = TOP_VERTEX;
    int unsigned cfg_dim_limit    = TOP_DIM;

    svu_pkg::t_out_item vertex_expected_q[$];
    int        fail_count = 0;
    bit        calm       = 1'b0;   // no idling on either side while set
    int        hold_cycles_req = 0; // receiver hold-off, counted down by the receiver

    simplex_vertex_unrank_step uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void build_pascal();
        logic [svu_pkg::COEFF_W:0] sum;
        for (int i = 0; i <= TOP_VERTEX; i++) begin
            for (int j = 0; j <= TOP_DIM; j++) begin
                if (j > i) begin
                    pascal[i][j] = svu_pkg::COEFF_ZERO;
                end else if (j == 0 || j == i) begin
                    pascal[i][j] = svu_pkg::COEFF_ONE;
                end else begin
                    sum = {1'b0, pascal[i-1][j-1]} + {1'b0, pascal[i-1][j]};
                    pascal[i][j] = sum[svu_pkg::COEFF_W] ? '1
                                                         : sum[svu_pkg::COEFF_W-1:0];
                end
            end
        end
    endfunction

    // Largest vertex not above the start whose coefficient fits under the rank
    function automatic svu_pkg::t_out_item search_vertex(svu_pkg::t_in_item item);
        int                          v;
        int                          count;
        int                          step;
        int                          probe;
        int                          k;
        logic [svu_pkg::COEFF_W-1:0] rank;
        svu_pkg::t_out_item          res;
        res.vertex = '0;
        res.error  = 1'b1;
        if (item.start_vertex > cfg_vertex_count || item.subset_size > cfg_dim_limit)
            return res;
        v    = item.start_vertex;
        k    = item.subset_size;
        rank = {1'b0, item.rank_value};
        if (pascal[v][k] > rank) begin
            count = v;
            while (count > 0) begin
                step  = count >> 1;
                probe = v - step;
                if (pascal[probe][k] > rank) begin
                    v     = (probe > 0) ? probe - 1 : 0;
                    count = count - (step + 1);
                end else begin
                    count = step;
                end
            end
        end
        // nothing qualifies (only k = 0 with rank 0)
        if (pascal[v][k] > rank)
            return res;
        res.vertex = v[svu_pkg::VTX_W-1:0];
        res.error  = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, and a counted hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cycles_req > 0) begin
            i_out_ready = 1'b0;
            hold_cycles_req = hold_cycles_req - 1;
        end else if (calm) begin
            i_out_ready = 1'b1;
        end else begin
            i_out_ready = ($urandom_range(99) >= 8);
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        svu_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vertex_expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result vertex=%0d error=%0b", $realtime,
                             o_out_data.vertex, o_out_data.error);
            end else begin
                want = vertex_expected_q.pop_front();
                if (o_out_data.vertex !== want.vertex || o_out_data.error !== want.error) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch vertex exp %0d got %0d, error exp %0b got %0b",
                                 $realtime, want.vertex, o_out_data.vertex,
                                 want.error, o_out_data.error);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    task automatic send_item(input int unsigned sv, input logic [62:0] rank,
                             input int unsigned k);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 8)
            gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data.start_vertex = sv[svu_pkg::VTX_W-1:0];
        i_in_data.rank_value   = rank;
        i_in_data.subset_size  = k[svu_pkg::DIM_W-1:0];
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        vertex_expected_q.push_back(search_vertex(i_in_data));
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        drop_valid();
        while (vertex_expected_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write, only with nothing in flight
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] v;
        wait_drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == svu_pkg::REG_VERTEX_COUNT) begin
            v = value & 32'h1FF;
            cfg_vertex_count = (v > TOP_VERTEX) ? TOP_VERTEX : v;
        end else begin
            v = value & 32'hF;
            cfg_dim_limit = (v > TOP_DIM) ? TOP_DIM : v;
        end
    endtask

    // Ranks clustered on coefficient boundaries so the search goes deep
    function automatic logic [62:0] pick_rank(int unsigned k);
        logic [svu_pkg::COEFF_W-1:0] r;
        int unsigned                 w;
        int unsigned                 kk;
        int unsigned                 mode;
        kk   = (k > TOP_DIM) ? TOP_DIM : k;
        w    = $urandom_range(cfg_vertex_count);
        mode = $urandom_range(9);
        if (mode < 5) begin
            r = pascal[w][kk];
            case ($urandom_range(2))
                0: r = r - 1;
                2: r = r + 1;
                default: ;
            endcase
        end else if (mode < 7) begin
            r = $urandom_range(1000);
        end else if (mode < 9) begin
            r = {$urandom, $urandom};
        end else begin
            r = '0;
        end
        return r[62:0];
    endfunction

    task automatic send_random(input int n);
        int unsigned sv;
        int unsigned k;
        repeat (n) begin
            if ($urandom_range(99) < 90)
                sv = $urandom_range(cfg_vertex_count);
            else
                sv = $urandom_range(svu_pkg::VTX_FIELD_MAX);
            if ($urandom_range(99) < 90)
                k = $urandom_range(cfg_dim_limit);
            else
                k = $urandom_range(svu_pkg::DIM_FIELD_MAX);
            send_item(sv, pick_rank(k), k);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: field extremes and the special cases
    task automatic test_reset_defaults();
        send_item(256, {63{1'b1}}, 8);               // start already qualifies
        send_item(256, '0, 8);                       // search down to 7
        send_item(0, '0, 0);                         // no vertex qualifies
        send_item(256, '0, 0);                       // searches to 0, then fails
        send_item(0, '0, 1);                         // C(0,1)=0 fits rank 0
        send_item(257, 63'd5, 2);                    // start beyond the table
        send_item(svu_pkg::VTX_FIELD_MAX, {63{1'b1}}, svu_pkg::DIM_FIELD_MAX);
        send_item(100, 63'd5, 9);                    // subset beyond the table
        send_item(200, pascal[100][3][62:0], 3);     // exact coefficient
        send_item(200, pascal[100][3][62:0] - 1, 3); // one below it
        send_item(256, 63'd37, 1);
        send_item(10, 63'd1000000, 3);
        send_item(256, pascal[255][8][62:0], 8);
        send_item(256, 63'h2AAA_AAAA_AAAA_AAAA, 4);
        send_item(1, 63'h5555_5555_5555_5555, 1);
    endtask

    // Smallest and saturated register settings, with masked upper data bits
    task automatic test_register_extremes();
        write_reg(svu_pkg::REG_VERTEX_COUNT, 32'd0);
        write_reg(svu_pkg::REG_DIM_LIMIT, 32'd0);
        send_item(0, '0, 0);
        send_item(0, 63'd1, 0);
        send_item(1, 63'd1, 0);
        send_item(0, 63'd1, 1);
        write_reg(svu_pkg::REG_VERTEX_COUNT, 32'd511);
        write_reg(svu_pkg::REG_DIM_LIMIT, 32'd15);
        send_item(256, '0, 8);
        send_item(256, 63'd1, 9);
        write_reg(svu_pkg::REG_DIM_LIMIT, 32'hABCD_0013);
        write_reg(svu_pkg::REG_VERTEX_COUNT, 32'd300);
        send_item(256, 63'd999, 3);
        send_item(256, 63'd999, 4);
        send_random(20);
    endtask

    // Result side held off while items keep coming
    task automatic test_output_stall();
        write_reg(svu_pkg::REG_VERTEX_COUNT, 32'd256);
        write_reg(svu_pkg::REG_DIM_LIMIT, 32'd8);
        send_item(5, 63'd3, 2);                      // absorbs the table build
        wait_drain();
        hold_cycles_req = 300;
        send_random(20);
    endtask

    // Sender waits for every result before going on
    task automatic test_drain_pause();
        send_random(10);
        wait_drain();
        send_random(10);
    endtask

    // Random phases under assorted register settings
    task automatic test_random_phases();
        calm = 1'b1;
        send_random(250);
        calm = 1'b0;
        send_random(250);
        write_reg(svu_pkg::REG_VERTEX_COUNT, $urandom_range(2, 255));
        write_reg(svu_pkg::REG_DIM_LIMIT, $urandom_range(1, 7));
        send_random(250);
        write_reg(svu_pkg::REG_VERTEX_COUNT, 32'd1);
        write_reg(svu_pkg::REG_DIM_LIMIT, 32'd8);
        send_random(100);
        write_reg(svu_pkg::REG_VERTEX_COUNT, 32'd256);
        write_reg(svu_pkg::REG_DIM_LIMIT, 32'd1);
        send_random(200);
        write_reg(svu_pkg::REG_VERTEX_COUNT, $urandom_range(svu_pkg::VTX_FIELD_MAX));
        write_reg(svu_pkg::REG_DIM_LIMIT, $urandom_range(svu_pkg::DIM_FIELD_MAX));
        send_random(250);
        write_reg(svu_pkg::REG_VERTEX_COUNT, 32'd256);
        write_reg(svu_pkg::REG_DIM_LIMIT, 32'd8);
        send_random(200);
    endtask

    // Test sequence
    initial begin
        build_pascal();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_output_stall();
        test_drain_pause();
        test_random_phases();
        wait_drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && vertex_expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit
    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/svu_pkg.sv
rtl/svu_alu.sv
rtl/svu_table.sv
rtl/simplex_vertex_unrank_step.sv
test/simplex_vertex_unrank_step_tb.sv
